// ===== rtl/nihac_pkg.sv =====
package nihac_pkg;

  localparam int IMAGE_BYTES = 8192;
  localparam int POS_W = $clog2(IMAGE_BYTES);

  localparam logic [POS_W-1:0] POS_SIG       = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HDR_SUM   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_ADLER_WD  = POS_W'(16);
  localparam logic [POS_W-1:0] POS_ADLER_RUN = POS_W'(20);
  localparam logic [POS_W-1:0] POS_GEN_END   = POS_W'(24);
  localparam logic [POS_W-1:0] POS_LAST      = POS_W'(IMAGE_BYTES - 1);

  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [7:0]  SIG_RESET = 8'h5a;

  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_BAD_SIG   = 2'd1,
    ST_BAD_HDR   = 2'd2,
    ST_BAD_ADLER = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       sig_ok;
    logic       hdr_ref;
    logic       hdr_add;
    logic       adler_word;
    logic       gen_word;
    logic       adler_run;
    logic       last;
  } beat_t;

endpackage

// ===== rtl/nihac_front.sv =====
module nihac_front
  import nihac_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       push,
  input  logic [7:0] image_byte,
  input  logic       q_full,
  output logic       q_push,
  output beat_t      q_beat
);

  logic [7:0]       signature;
  logic [POS_W-1:0] pos;

  assign cfg_ready = 1'b1;
  assign q_push    = push && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      signature <= SIG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      signature <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (q_push) begin
      if (pos == POS_LAST) begin
        pos <= '0;
      end else begin
        pos <= pos + POS_W'(1);
      end
    end
  end

  always_comb begin
    q_beat.data       = image_byte;
    q_beat.first      = (pos == POS_SIG);
    q_beat.sig_ok     = (image_byte == signature);
    q_beat.hdr_ref    = (pos == POS_HDR_SUM);
    q_beat.hdr_add    = (pos > POS_HDR_SUM) && (pos < POS_ADLER_WD);
    q_beat.adler_word = (pos >= POS_ADLER_WD) && (pos < POS_ADLER_RUN);
    q_beat.gen_word   = (pos >= POS_ADLER_RUN) && (pos < POS_GEN_END);
    q_beat.adler_run  = (pos >= POS_ADLER_RUN);
    q_beat.last       = (pos == POS_LAST);
  end

endmodule

// ===== rtl/nihac_fifo.sv =====
module nihac_fifo
  import nihac_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  beat_t wr_beat,
  output logic  full,
  input  logic  rd,
  output beat_t rd_beat,
  output logic  empty
);

  beat_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_beat = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wr_ptr] <= wr_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr && !full) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd && !empty) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({wr && !full, rd && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/nihac_back.sv =====
module nihac_back
  import nihac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  beat_t       q_beat,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [31:0] generation,
  output logic [31:0] computed_adler,
  output logic [7:0]  computed_header_sum
);

  logic [15:0] low_sum, high_sum;
  logic [11:0] hdr_run;
  logic [7:0]  hdr_ref;
  logic        sig_matched;
  logic [31:0] adler_word;
  logic [31:0] gen_word;

  logic [15:0] low_sum_next, high_sum_next;
  logic [11:0] hdr_run_next;
  logic [7:0]  hdr_ref_next;
  logic        sig_matched_next;
  logic [31:0] adler_word_next;
  logic [31:0] gen_word_next;
  logic [16:0] low_add, high_add;

  logic        fin_valid;
  logic [15:0] fin_low, fin_high;
  logic [11:0] fin_hdr_run;
  logic [7:0]  fin_hdr_ref;
  logic        fin_sig;
  logic [31:0] fin_adler_word;
  logic [31:0] fin_gen;

  logic        out_valid;
  logic        out_load;
  logic        fin_adv;
  logic        fin_free;
  logic [8:0]  fold1;
  logic [7:0]  fold2;
  status_t     status_next;

  assign out_load = !out_valid || pop;
  assign fin_adv  = fin_valid && out_load;
  assign fin_free = !fin_valid || fin_adv;
  assign q_pop    = !q_empty && (!q_beat.last || fin_free);

  always_comb begin
    sig_matched_next = sig_matched;
    hdr_run_next     = hdr_run;
    hdr_ref_next     = hdr_ref;
    adler_word_next  = adler_word;
    gen_word_next    = gen_word;
    low_sum_next     = low_sum;
    high_sum_next    = high_sum;
    low_add          = {1'b0, low_sum} + {9'd0, q_beat.data};
    if (low_add >= ADLER_MOD) begin
      low_add = low_add - ADLER_MOD;
    end
    high_add = {1'b0, high_sum} + low_add;
    if (high_add >= ADLER_MOD) begin
      high_add = high_add - ADLER_MOD;
    end
    if (q_beat.first) begin
      sig_matched_next = q_beat.sig_ok;
      hdr_run_next     = {4'd0, q_beat.data};
    end
    if (q_beat.hdr_ref) begin
      hdr_ref_next = q_beat.data;
    end
    if (q_beat.hdr_add) begin
      hdr_run_next = hdr_run + {4'd0, q_beat.data};
    end
    if (q_beat.adler_word) begin
      adler_word_next = {adler_word[23:0], q_beat.data};
    end
    if (q_beat.gen_word) begin
      gen_word_next = {gen_word[23:0], q_beat.data};
    end
    if (q_beat.adler_run) begin
      low_sum_next  = low_add[15:0];
      high_sum_next = high_add[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_sum     <= 16'd1;
      high_sum    <= 16'd0;
      hdr_run     <= 12'd0;
      hdr_ref     <= 8'd0;
      sig_matched <= 1'b0;
      adler_word  <= 32'd0;
      gen_word    <= 32'd0;
    end else if (q_pop) begin
      if (q_beat.last) begin
        low_sum     <= 16'd1;
        high_sum    <= 16'd0;
        hdr_run     <= 12'd0;
        hdr_ref     <= 8'd0;
        sig_matched <= 1'b0;
        adler_word  <= 32'd0;
        gen_word    <= 32'd0;
      end else begin
        low_sum     <= low_sum_next;
        high_sum    <= high_sum_next;
        hdr_run     <= hdr_run_next;
        hdr_ref     <= hdr_ref_next;
        sig_matched <= sig_matched_next;
        adler_word  <= adler_word_next;
        gen_word    <= gen_word_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (q_pop && q_beat.last) begin
      fin_valid <= 1'b1;
    end else if (fin_adv) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_beat.last) begin
      fin_low        <= low_sum_next;
      fin_high       <= high_sum_next;
      fin_hdr_run    <= hdr_run_next;
      fin_hdr_ref    <= hdr_ref_next;
      fin_sig        <= sig_matched_next;
      fin_adler_word <= adler_word_next;
      fin_gen        <= gen_word_next;
    end
  end

  always_comb begin
    fold1 = {1'b0, fin_hdr_run[7:0]} + {5'd0, fin_hdr_run[11:8]};
    fold2 = fold1[7:0] + {7'd0, fold1[8]};
    priority if (!fin_sig) begin
      status_next = ST_BAD_SIG;
    end else if (fold2 != fin_hdr_ref) begin
      status_next = ST_BAD_HDR;
    end else if ({fin_high, fin_low} != fin_adler_word) begin
      status_next = ST_BAD_ADLER;
    end else begin
      status_next = ST_VALID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_adv) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_adv) begin
      status              <= status_next;
      generation          <= (status_next == ST_VALID) ? fin_gen : 32'd0;
      computed_adler      <= {fin_high, fin_low};
      computed_header_sum <= fold2;
    end
  end

  assign empty = !out_valid;

endmodule

// ===== rtl/nvram_image_header_adler_check.sv =====
// Path: the last byte of an image goes through the beat queue, the fin
// registers and the result registers before it shows on the result ports.
// Throughput: one byte per cycle while full is low; one result per image
// of IMAGE_BYTES bytes.
// Reset: synchronous, clears the queues and all image state; signature = 0x5a.
module nvram_image_header_adler_check
  import nihac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  image_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [31:0] generation,
  output logic [31:0] computed_adler,
  output logic [7:0]  computed_header_sum
);

  beat_t in_beat;
  beat_t head_beat;
  logic  q_push;
  logic  q_pop;
  logic  q_empty;

  nihac_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .push       (push),
    .image_byte (image_byte),
    .q_full     (full),
    .q_push     (q_push),
    .q_beat     (in_beat)
  );

  nihac_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_beat (in_beat),
    .full    (full),
    .rd      (q_pop),
    .rd_beat (head_beat),
    .empty   (q_empty)
  );

  nihac_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .q_beat              (head_beat),
    .q_empty             (q_empty),
    .q_pop               (q_pop),
    .empty               (empty),
    .pop                 (pop),
    .status              (status),
    .generation          (generation),
    .computed_adler      (computed_adler),
    .computed_header_sum (computed_header_sum)
  );

  a_gen_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_VALID) |-> generation == 32'd0)
    else $error("generation not zero on failed image");

  a_adler_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ({1'b0, computed_adler[31:16]} < ADLER_MOD &&
                {1'b0, computed_adler[15:0]} < ADLER_MOD))
    else $error("adler sum out of range");

  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    full |-> !q_empty)
    else $error("beat queue full and empty");

endmodule
